>>> rtl/bgtr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap glyph text renderer package
// Shared payload types, control structs and fixed constants.
// ----------------------------------------------------------------------------
package bgtr_pkg;

    localparam int FONT_BYTES    = 3040;
    localparam int FONT_ADDR_W   = 12;
    localparam int GLYPH_BITS    = 16;
    localparam int FRAME_ADDR_W  = 19;
    localparam int MASK_W        = 11;
    localparam int COLOR_W       = 16;
    localparam int COORD_W       = 10;
    localparam int DIM_W         = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_SUBST = 8'h3F;

    localparam logic [COORD_W-1:0] CURSOR_MAX  = 10'h3FF;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hFFFF;

    typedef struct packed {
        logic                   operation;
        logic [FONT_ADDR_W-1:0] font_address;
        logic [7:0]             font_byte;
        logic [7:0]             char_code;
        logic                   new_string;
        logic [COORD_W-1:0]     start_x;
        logic [COORD_W-1:0]     start_y;
    } bgtr_in_t;

    typedef struct packed {
        logic [FRAME_ADDR_W-1:0] frame_address;
        logic [MASK_W-1:0]       pixel_mask;
        logic [COLOR_W-1:0]      pixel_color;
        logic                    last_row;
    } bgtr_out_t;

    typedef struct packed {
        logic accept_load;
        logic accept_draw;
        logic setup;
        logic issue;
    } bgtr_cmd_t;

    typedef struct packed {
        logic can_advance;
        logic row_last;
    } bgtr_status_t;

endpackage

>>> rtl/bitmap_glyph_text_renderer_core.sv
// ----------------------------------------------------------------------------
// Bitmap glyph text renderer core
// Loads a bitmap font byte by byte and renders characters as glyph row masks.
//
//   Channel   Ports                        Carries
//   input     s_valid / s_ready / s_data   load or draw transaction
//   output    m_valid / m_ready / m_data   one glyph row result
//   config    cfg_we / cfg_wdata           text color
//
// A load is written to the font store when accepted. A draw is accepted, then
// sets up the row address, then reads one font-store row per cycle while the output is not stalled.
// A stalled output freezes the row pipeline; no input is taken during a draw.
// Reset clears the cursor and restores the text color; the font store keeps
// its contents and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_glyph_text_renderer_core #(
    parameter int FRAME_WIDTH   = 800,
    parameter int FRAME_HEIGHT  = 480,
    parameter int GLYPH_ROWS    = 16,
    parameter int GLYPH_COLUMNS = 11,
    parameter int CHAR_ADVANCE  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bgtr_pkg::bgtr_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bgtr_pkg::bgtr_out_t  m_data,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);
    import bgtr_pkg::*;

    bgtr_cmd_t    cmd;
    bgtr_status_t status;

    bgtr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .operation (s_data.operation),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .status    (status)
    );

    bgtr_datapath #(
        .FRAME_WIDTH   (FRAME_WIDTH),
        .FRAME_HEIGHT  (FRAME_HEIGHT),
        .GLYPH_ROWS    (GLYPH_ROWS),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .CHAR_ADVANCE  (CHAR_ADVANCE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> rtl/bgtr_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap glyph text renderer controller
// Sequences transaction intake, cursor setup and the per-row read issue.
// ----------------------------------------------------------------------------
module bgtr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  operation,
    output logic                  s_ready,
    output bgtr_pkg::bgtr_cmd_t   cmd,
    input  bgtr_pkg::bgtr_status_t status
);
    import bgtr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROWS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.accept_load = accept && (operation == OP_LOAD);
        cmd.accept_draw = accept && (operation == OP_DRAW);
        cmd.setup       = (state_reg == ST_SETUP);
        cmd.issue       = (state_reg == ST_ROWS) && status.can_advance;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept_draw) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_ROWS;
            end
            ST_ROWS: begin
                if (cmd.issue && status.row_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/bgtr_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap glyph text renderer datapath
// Font store, cursor, row address walk, clipping and the result register.
// ----------------------------------------------------------------------------
module bgtr_datapath #(
    parameter int FRAME_WIDTH   = 800,
    parameter int FRAME_HEIGHT  = 480,
    parameter int GLYPH_ROWS    = 16,
    parameter int GLYPH_COLUMNS = 11,
    parameter int CHAR_ADVANCE  = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bgtr_pkg::bgtr_in_t      s_data,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata,
    input  bgtr_pkg::bgtr_cmd_t     cmd,
    output bgtr_pkg::bgtr_status_t  status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bgtr_pkg::bgtr_out_t     m_data
);
    import bgtr_pkg::*;

    localparam int ROW_W = $clog2(GLYPH_ROWS);
    localparam logic [DIM_W-1:0] FW = DIM_W'(FRAME_WIDTH);
    localparam logic [DIM_W-1:0] FH = DIM_W'(FRAME_HEIGHT);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [COORD_W:0] ADVANCE = (COORD_W + 1)'(CHAR_ADVANCE);
    localparam logic [FONT_ADDR_W-1:0] FONT_END = FONT_ADDR_W'(FONT_BYTES);

    logic [7:0] font_mem [FONT_BYTES];

    logic [COLOR_W-1:0]      text_color_reg;
    logic [COORD_W-1:0]      cursor_x_reg;
    logic [COORD_W-1:0]      cursor_y_reg;
    logic [FONT_ADDR_W-1:0]  glyph_base_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [FRAME_ADDR_W-1:0] addr_acc_reg;
    logic [DIM_W-1:0]        y_acc_reg;
    logic                    x_ok_reg;
    logic [GLYPH_COLUMNS-1:0] col_ok_reg;

    logic                    s1_valid_reg;
    logic [FRAME_ADDR_W-1:0] s1_addr_reg;
    logic                    s1_vis_reg;
    logic                    s1_last_reg;
    logic [GLYPH_COLUMNS-1:0] s1_col_ok_reg;
    logic [7:0]              s1_hi_reg;
    logic [7:0]              s1_lo_reg;

    logic                    out_valid_reg;
    bgtr_out_t               out_reg;

    logic                    pipe_en;
    logic [7:0]              code;
    logic [6:0]              glyph_index;
    logic [FONT_ADDR_W-1:0]  rd_addr;
    logic [FONT_ADDR_W-1:0]  rd_addr_lo;
    logic [21:0]             row_product;
    logic [GLYPH_COLUMNS-1:0] col_ok_next;
    logic [COORD_W:0]        cursor_sum;
    logic [GLYPH_BITS-1:0]   glyph_bits;
    logic [GLYPH_BITS-1:0]   wide_mask;

    assign pipe_en = !out_valid_reg || m_ready;
    assign status.can_advance = pipe_en;
    assign status.row_last    = (row_reg == ROW_LAST);

    always_comb begin
        code = s_data.char_code;
        if (code < CHAR_FIRST || code > CHAR_LAST) begin
            code = CHAR_SUBST;
        end
        glyph_index = 7'(code - CHAR_FIRST);
    end

    assign rd_addr    = glyph_base_reg + FONT_ADDR_W'({row_reg, 1'b0});
    assign rd_addr_lo = rd_addr + FONT_ADDR_W'(1);
    assign row_product = {12'b0, cursor_y_reg} * {10'b0, FW} + 22'(cursor_x_reg);
    assign cursor_sum  = {1'b0, cursor_x_reg} + ADVANCE;

    always_comb begin
        for (int col = 0; col < GLYPH_COLUMNS; col++) begin
            col_ok_next[col] = (DIM_W'(cursor_x_reg) + DIM_W'(col)) < FW;
        end
    end

    always_comb begin
        glyph_bits = {s1_hi_reg, s1_lo_reg};
        wide_mask  = '0;
        for (int col = 0; col < GLYPH_COLUMNS; col++) begin
            wide_mask[GLYPH_COLUMNS-1-col] = s1_vis_reg && s1_col_ok_reg[col]
                                             && glyph_bits[GLYPH_BITS-1-col];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_load && s_data.font_address < FONT_END) begin
            font_mem[s_data.font_address] <= s_data.font_byte;
        end
        if (cmd.issue) begin
            s1_hi_reg <= font_mem[rd_addr];
            s1_lo_reg <= font_mem[rd_addr_lo];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= COLOR_RESET;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                text_color_reg <= cfg_wdata;
            end
            if (cmd.accept_draw && s_data.new_string) begin
                cursor_x_reg <= s_data.start_x;
                cursor_y_reg <= s_data.start_y;
            end
            if (cmd.issue && status.row_last) begin
                if (cursor_sum > {1'b0, CURSOR_MAX}) begin
                    cursor_x_reg <= CURSOR_MAX;
                end else begin
                    cursor_x_reg <= cursor_sum[COORD_W-1:0];
                end
            end
            if (pipe_en) begin
                s1_valid_reg  <= cmd.issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_draw) begin
            glyph_base_reg <= {glyph_index, 5'b0};
        end
        if (cmd.setup) begin
            row_reg      <= '0;
            addr_acc_reg <= row_product[FRAME_ADDR_W-1:0];
            y_acc_reg    <= DIM_W'(cursor_y_reg);
            x_ok_reg     <= DIM_W'(cursor_x_reg) < FW;
            col_ok_reg   <= col_ok_next;
        end
        if (cmd.issue) begin
            row_reg       <= row_reg + ROW_W'(1);
            addr_acc_reg  <= addr_acc_reg + FRAME_ADDR_W'(FW);
            y_acc_reg     <= y_acc_reg + DIM_W'(1);
            s1_addr_reg   <= addr_acc_reg;
            s1_vis_reg    <= x_ok_reg && (y_acc_reg < FH);
            s1_last_reg   <= status.row_last;
            s1_col_ok_reg <= col_ok_reg;
        end
        if (pipe_en && s1_valid_reg) begin
            out_reg.frame_address <= s1_vis_reg ? s1_addr_reg : '0;
            out_reg.pixel_mask    <= wide_mask[MASK_W-1:0];
            out_reg.pixel_color   <= text_color_reg;
            out_reg.last_row      <= s1_last_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
